// ===== rtl/lum_pkg.sv =====
// ----------------------------------------------------------------------------
// lum_pkg: shared types and constants for the luma unsharp mask
// Widths, register indexes and the request record passed front to back.
// ----------------------------------------------------------------------------
package lum_pkg;
	localparam int DefMaxWidth = 8192;
	localparam int DefRadius   = 3;
	localparam int LineSlots   = 8;
	localparam int Taps        = 7;
	localparam logic [23:0] OutMaxQ = 24'd16776960;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_GAIN   = 2'd2;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROW,
		ST_SUM,
		ST_FIN
	} back_st_t;

	// request from front to back: one pixel store and/or one result to compute
	typedef struct packed {
		logic        store;
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic [15:0] in_row;
		logic [13:0] in_col;
		logic        emit;
		logic [15:0] out_row;
		logic [13:0] out_col;
		logic        last;
	} req_t;

	function automatic logic [23:0] luma_of(input logic [15:0] r, input logic [15:0] g,
		input logic [15:0] b);
		logic [33:0] s;
		begin
			s = 34'(r) * 34'd19595 + 34'(g) * 34'd38470 + 34'(b) * 34'd7471;
			luma_of = s[31:8];
		end
	endfunction
endpackage

// ===== rtl/lum_front.sv =====
// ----------------------------------------------------------------------------
// lum_front: input acceptance and position tracking
// Counts input and output raster positions, decides readiness, issues requests.
// ----------------------------------------------------------------------------
module lum_front import lum_pkg::*; #(
	parameter int MAX_WIDTH = DefMaxWidth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] eff_w,
	input  logic [15:0] eff_h,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic        op,
	input  logic [15:0] red,
	input  logic [15:0] green,
	input  logic [15:0] blue,
	output logic        req_valid,
	input  logic        req_ready,
	output req_t        req
);
	logic [15:0] in_col_q, in_row_q, out_col_q, out_row_q;
	logic        take, do_store, ready_out;
	logic [15:0] nic, nir;
	logic [15:0] need_r, need_c;
	logic        in_done;

	assign s_tready = req_ready;
	assign take     = s_tvalid && s_tready;
	assign in_done  = (in_row_q >= eff_h);
	assign do_store = (op == OP_PIXEL) && !in_done;

	always_comb begin
		nic = in_col_q;
		nir = in_row_q;
		if (do_store) begin
			if (in_col_q + 16'd1 >= eff_w) begin
				nic = '0;
				nir = in_row_q + 16'd1;
			end else begin
				nic = in_col_q + 16'd1;
			end
		end
		need_r = (32'(out_row_q) + 32'd3 < 32'(eff_h)) ? out_row_q + 16'd3 : eff_h - 16'd1;
		need_c = (32'(out_col_q) + 32'd3 < 32'(eff_w)) ? out_col_q + 16'd3 : eff_w - 16'd1;
		// need position strictly before the new input position
		ready_out = (out_row_q < eff_h) &&
			((need_r < nir) || ((need_r == nir) && (need_c < nic)));
	end

	always_comb begin
		req.store   = do_store;
		req.red     = red;
		req.green   = green;
		req.blue    = blue;
		req.in_row  = in_row_q;
		req.in_col  = in_col_q[13:0];
		req.emit    = ready_out;
		req.out_row = out_row_q;
		req.out_col = out_col_q[13:0];
		req.last    = (out_row_q == eff_h - 16'd1) && (out_col_q == eff_w - 16'd1);
	end
	assign req_valid = s_tvalid && (do_store || ready_out);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_we) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (take) begin
			in_col_q <= nic;
			in_row_q <= nir;
			if (ready_out) begin
				if (req.last) begin
					in_col_q  <= '0;
					in_row_q  <= '0;
					out_col_q <= '0;
					out_row_q <= '0;
				end else if (out_col_q + 16'd1 >= eff_w) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + 16'd1;
				end else begin
					out_col_q <= out_col_q + 16'd1;
				end
			end
		end
	end

	localparam int MW = MAX_WIDTH;
	assert property (@(posedge clk) disable iff (!arst_n)
		32'(in_col_q) < MW || in_col_q == 16'd0)
		else $error("input column beyond line length");
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid |-> s_tvalid)
		else $error("request without input");
	assert property (@(posedge clk) disable iff (!arst_n)
		(take && req.emit && req.last && !cfg_we) |=> (out_row_q == 16'd0 && in_row_q == 16'd0))
		else $error("frame end did not restart positions");
endmodule

// ===== rtl/lum_queue.sv =====
// ----------------------------------------------------------------------------
// lum_queue: short request queue between front and back
// Two-entry FIFO, registered storage.
// ----------------------------------------------------------------------------
module lum_queue import lum_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  req_t in_req,
	output logic out_valid,
	input  logic out_ready,
	output req_t out_req
);
	req_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_req   = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop  = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1))
		else $error("queue count not advanced");
	assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (cnt_q == $past(cnt_q) - 2'd1))
		else $error("queue count not reduced");
endmodule

// ===== rtl/lum_back.sv =====
// ----------------------------------------------------------------------------
// lum_back: line store and sharpening datapath
// Stores pixels to line memories, then walks seven rows to build the blur.
// ----------------------------------------------------------------------------
module lum_back import lum_pkg::*; #(
	parameter int MAX_WIDTH = DefMaxWidth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] eff_w,
	input  logic [15:0] eff_h,
	input  logic [10:0] eff_gain,
	input  logic        req_valid,
	output logic        req_ready,
	input  req_t        req,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,
	output logic        m_tlast
);
	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int LD   = LineSlots * (1 << CW);
	localparam int AW   = $clog2(LD);

	logic [23:0] luma_mem [LD];
	logic [47:0] rgb_mem  [LD];

	back_st_t    st_q, st_nx;
	logic [2:0]  tap_q;    // row tap index 0..6
	logic [2:0]  ph_q;     // column phase 0..7 within a row tap
	req_t        cur_q;
	logic [23:0] rd_luma_s1;
	logic [47:0] rd_rgb_s1;
	logic [23:0] ctr_luma_q;
	logic [47:0] ctr_rgb_q;
	logic [31:0] rsum_q;
	logic [39:0] acc_q;
	logic        rd_v_s1;
	logic [2:0]  rd_ph_s1;
	logic        out_v_q;
	logic [47:0] out_d_q;
	logic        out_l_q;
	logic        start;
	logic [AW-1:0] rd_addr, wr_addr;
	logic signed [17:0] rr;
	logic signed [17:0] cc;
	logic [15:0] row_c, col_c;
	logic [4:0]  wr_t, wc_t;

	function automatic logic [4:0] binw(input logic [2:0] i);
		unique case (i)
			3'd0, 3'd6: binw = 5'd1;
			3'd1, 3'd5: binw = 5'd6;
			3'd2, 3'd4: binw = 5'd15;
			3'd3:       binw = 5'd20;
			default:    binw = 5'd0;
		endcase
	endfunction

	// a result request starts only when the output slot is free; a pure store waits only for the idle state
	assign start     = (st_q == ST_IDLE) && req_valid && (!req.emit || !out_v_q || m_tready);
	assign req_ready = start;

	always_comb begin
		unique case (st_q)
			ST_IDLE: st_nx = (start && req.emit) ? ST_ROW : ST_IDLE;
			ST_ROW:  st_nx = (tap_q == 3'd6 && ph_q == 3'd7) ? ST_SUM : ST_ROW;
			ST_SUM:  st_nx = ST_FIN;
			ST_FIN:  st_nx = ST_IDLE;
			default: st_nx = ST_IDLE;
		endcase
	end

	// address: phase 0..6 are column taps, phase 7 reads the center pixel
	always_comb begin
		rr = $signed({2'b0, cur_q.out_row}) + $signed(18'(tap_q)) - 18'sd3;
		if (ph_q == 3'd7) rr = $signed({2'b0, cur_q.out_row});
		if (rr < 0) row_c = '0;
		else if (rr >= $signed({2'b0, eff_h})) row_c = eff_h - 16'd1;
		else row_c = rr[15:0];
		cc = $signed({4'b0, cur_q.out_col}) + $signed(18'(ph_q)) - 18'sd3;
		if (ph_q == 3'd7) cc = $signed({4'b0, cur_q.out_col});
		if (cc < 0) col_c = '0;
		else if (cc >= $signed({2'b0, eff_w})) col_c = eff_w - 16'd1;
		else col_c = cc[15:0];
		rd_addr = AW'({row_c[2:0], col_c[CW-1:0]});
		wr_addr = AW'({req.in_row[2:0], req.in_col[CW-1:0]});
	end

	always_ff @(posedge clk) begin
		if (start && req.store) begin
			luma_mem[wr_addr] <= luma_of(req.red, req.green, req.blue);
			rgb_mem[wr_addr]  <= {req.blue, req.green, req.red};
		end
		rd_luma_s1 <= luma_mem[rd_addr];
		rd_rgb_s1  <= rgb_mem[rd_addr];
	end

	always_comb begin
		wr_t = binw(tap_q - 3'd0);
		wc_t = binw(rd_ph_s1);
	end

	// datapath: accumulate row sums, fold into vertical accumulator
	logic [2:0]  acc_tap_s1;
	logic signed [25:0] detail;
	logic signed [37:0] prod;
	logic signed [29:0] offs;
	logic signed [28:0] vch [3];
	logic [47:0] fin;
	logic [23:0] blur;

	always_comb begin
		blur   = acc_q[35:12];
		detail = $signed({2'b0, ctr_luma_q}) - $signed({2'b0, blur});
		prod   = $signed({27'b0, eff_gain - 11'd256}) * 38'(detail);
		offs   = 30'(prod >>> 8);
		for (int k = 0; k < 3; k++) begin
			vch[k] = $signed({5'b0, ctr_rgb_q[16*k +: 16], 8'b0}) + 29'(offs);
			if (vch[k] < 0) fin[16*k +: 16] = '0;
			else if (vch[k] > $signed({5'b0, OutMaxQ})) fin[16*k +: 16] = 16'hFFFF;
			else fin[16*k +: 16] = vch[k][23:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			tap_q   <= '0;
			ph_q    <= '0;
			rd_v_s1 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			st_q <= st_nx;
			if (out_v_q && m_tready) out_v_q <= 1'b0;
			if (start) begin
				tap_q <= '0;
				ph_q  <= '0;
			end else if (st_q == ST_ROW) begin
				ph_q <= ph_q + 3'd1;
				if (ph_q == 3'd7) tap_q <= tap_q + 3'd1;
			end
			rd_v_s1 <= (st_q == ST_ROW);
			if (st_q == ST_FIN) out_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cur_q  <= req;
			acc_q  <= '0;
			rsum_q <= '0;
		end
		rd_ph_s1   <= ph_q;
		acc_tap_s1 <= tap_q;
		if (rd_v_s1) begin
			if (rd_ph_s1 == 3'd7) begin
				acc_q <= acc_q + 40'(rsum_q) * 40'(binw(acc_tap_s1));
				rsum_q <= '0;
				ctr_luma_q <= rd_luma_s1;
				ctr_rgb_q  <= rd_rgb_s1;
			end else begin
				rsum_q <= rsum_q + 32'(rd_luma_s1) * 32'(wc_t);
			end
		end
		if (st_q == ST_FIN) begin
			out_d_q <= fin;
			out_l_q <= cur_q.last;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_d_q;
	assign m_tlast  = out_l_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_FIN) |=> out_v_q)
		else $error("result not posted");
	assert property (@(posedge clk) disable iff (!arst_n)
		start |-> (st_q == ST_IDLE))
		else $error("request taken while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_ROW && wr_t == 5'd0) |-> 1'b0)
		else $error("bad tap weight");
endmodule

// ===== rtl/luma_unsharp_mask_7x7.sv =====
// ----------------------------------------------------------------------------
// luma_unsharp_mask_7x7: 7x7 binomial luma unsharp mask on 16-bit RGB
// Top level: configuration registers, front end, request queue, back end.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order on the slave stream (tuser = 1 marks a drain
// request, which stores nothing). Luma is blurred with a 7x7 binomial kernel
// over replicated borders and the scaled detail is added to each channel.
// Results leave about three rows and three columns behind the input, with
// tlast on the frame's final pixel; send drain requests after the frame to
// flush the tail. A request that yields a result holds the back end while it
// starts, makes 7 rows x 8 line memory reads through a single read port,
// folds the last row and forms the result; it also waits until the output
// register is free. A pure store only writes the line memories.
// Any register write restarts the frame. Line memories hold 8 rows of
// MAX_WIDTH and need no clearing pass.
module luma_unsharp_mask_7x7 import lum_pkg::*; #(
	parameter int MAX_WIDTH = DefMaxWidth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // in_red, in_green, in_blue
	input  logic        s_tuser,   // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // out_red, out_green, out_blue
	output logic        m_tlast    // frame_end
);
	logic [13:0] width_q;
	logic [15:0] height_q;
	logic [10:0] gain_q;
	logic [15:0] eff_w, eff_h;
	logic [10:0] eff_gain;
	logic        restart;
	logic        fq_valid, fq_ready, bq_valid, bq_ready;
	req_t        f_req, b_req;

	assign restart = cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT ||
		cfg_index == REG_GAIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 14'd8192;
			height_q <= 16'd1;
			gain_q   <= 11'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data[13:0];
				REG_HEIGHT: height_q <= cfg_data;
				REG_GAIN:   gain_q   <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q == 14'd0) eff_w = 16'd1;
		else if (32'(width_q) > MAX_WIDTH) eff_w = 16'(MAX_WIDTH);
		else eff_w = {2'b0, width_q};
		eff_h = (height_q == 16'd0) ? 16'd1 : height_q;
		if (gain_q < 11'd256) eff_gain = 11'd256;
		else if (gain_q > 11'd1280) eff_gain = 11'd1280;
		else eff_gain = gain_q;
	end

	lum_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk, .arst_n, .cfg_we(restart), .eff_w, .eff_h,
		.s_tvalid, .s_tready, .op(s_tuser),
		.red(s_tdata[15:0]), .green(s_tdata[31:16]), .blue(s_tdata[47:32]),
		.req_valid(fq_valid), .req_ready(fq_ready), .req(f_req)
	);

	lum_queue u_queue (
		.clk, .arst_n, .in_valid(fq_valid), .in_ready(fq_ready), .in_req(f_req),
		.out_valid(bq_valid), .out_ready(bq_ready), .out_req(b_req)
	);

	lum_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
		.clk, .arst_n, .eff_w, .eff_h, .eff_gain,
		.req_valid(bq_valid), .req_ready(bq_ready), .req(b_req),
		.m_tvalid, .m_tready, .m_tdata, .m_tlast
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid)
		else $error("result dropped while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(m_tdata))
		else $error("result changed while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		eff_gain >= 11'd256 && eff_gain <= 11'd1280)
		else $error("gain out of range");
endmodule
